/* src/rational_arithmetic_unit_defines.svh */
// Assertion macros for the rational arithmetic unit RTL.
// Empty bodies when SYNTH is defined.
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`ifndef SYNTH
`define RAU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RAU_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RAU_ASSERT(label, clk, rst_n, prop, msg)
`define RAU_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

/* src/rau_pkg.sv */
// Package for the rational arithmetic unit: opcodes, controller/datapath structs.
// No dependencies.
package rau_pkg;
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_CMP = 3'd4;
    localparam logic [2:0] OP_RED = 3'd5;

    // datapath step commands
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_MUL1,
        CMD_MUL2,
        CMD_FORM,
        CMD_G_INIT,
        CMD_G_STEP,
        CMD_DIV_INIT,
        CMD_DIV_STEP,
        CMD_FINISH
    } cmd_t;

    typedef struct packed {
        logic early_done;  // result settled without reduction
        logic gcd_done;
        logic div_done;
    } status_t;
endpackage

/* src/rau_datapath.sv */
// Datapath of the rational arithmetic unit: cross products, binary gcd,
// and a restoring divider. Depends on rau_pkg.
module rau_datapath #(
    parameter int WORD_BITS = 32
) (
    input  logic                clk,
    input  rau_pkg::cmd_t       cmd,
    input  logic [2:0]          opcode,
    input  logic [31:0]         a_num,
    input  logic [31:0]         a_den,
    input  logic [31:0]         b_num,
    input  logic [31:0]         b_den,
    output rau_pkg::status_t    status,
    output logic [31:0]         res_num,
    output logic [30:0]         res_den,
    output logic                res_valid,
    output logic [1:0]          cmp_sign
);
    localparam logic [63:0] HALF = 64'd1 << (WORD_BITS - 1);

    logic [2:0]  op_reg;
    logic        an_s_reg, ad_s_reg, bn_s_reg, bd_s_reg;
    logic [31:0] an_m_reg, ad_m_reg, bn_m_reg, bd_m_reg;
    logic [63:0] p1_reg, p2_reg, p3_reg;     // cross products
    logic        s1_reg, s2_reg, s3_reg;
    logic [63:0] nm_reg, dm_reg;              // value to reduce
    logic        nneg_reg, bad_reg, early_reg;
    logic [1:0]  cmp_reg;
    logic [63:0] gx_reg, gy_reg;
    logic [6:0]  gk_reg;
    logic [63:0] g_reg;
    logic [63:0] q_reg, r_reg;                // shared divider
    logic [6:0]  dcnt_reg;
    logic        dsel_reg;                    // 0: numerator, 1: denominator
    logic [63:0] qn_reg;
    logic [31:0] rn_reg;
    logic [30:0] rd_reg;
    logic        rv_reg;
    logic [1:0]  rc_reg;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        mag32 = v[31] ? (32'd0 - v) : v;
    endfunction

    // operand pairs for the two multiplier steps
    logic [31:0] ma1, mb1, ma2, mb2;
    logic        ms1, ms2;
    always_comb
    begin
        ma1 = an_m_reg; mb1 = bd_m_reg; ms1 = an_s_reg ^ bd_s_reg;
        ma2 = ad_m_reg; mb2 = bn_m_reg; ms2 = ad_s_reg ^ bn_s_reg;
        if (op_reg == rau_pkg::OP_MUL)
        begin
            mb1 = bn_m_reg; ms1 = an_s_reg ^ bn_s_reg;
            mb2 = bd_m_reg; ms2 = ad_s_reg ^ bd_s_reg;
        end
    end

    // signed-magnitude add of p1 and (+/-)p2
    logic        s2e;
    logic [63:0] sum_m;
    logic        sum_s;
    always_comb
    begin
        s2e = s2_reg ^ ((op_reg == rau_pkg::OP_SUB) || (op_reg == rau_pkg::OP_CMP));
        if (s1_reg == s2e)
        begin
            sum_m = p1_reg + p2_reg; sum_s = s1_reg;
        end
        else if (p1_reg >= p2_reg)
        begin
            sum_m = p1_reg - p2_reg; sum_s = s1_reg;
        end
        else
        begin
            sum_m = p2_reg - p1_reg; sum_s = s2e;
        end
    end

    logic [63:0] gy_sh, gx_new, gy_new, r_sh, r_sub;
    logic [63:0] ylo, yhi;
    always_comb
    begin
        gy_sh = gy_reg;
        if (!gy_reg[0])
            gy_sh = gy_reg >> 1;
        ylo = (gx_reg > gy_sh) ? gy_sh : gx_reg;
        yhi = (gx_reg > gy_sh) ? gx_reg : gy_sh;
        gx_new = gx_reg;
        gy_new = gy_sh;
        if (gy_reg[0])
        begin
            gx_new = ylo;
            gy_new = yhi - ylo;
        end
        r_sh  = {r_reg[62:0], q_reg[63]};
        r_sub = r_sh - g_reg;
    end

    assign status.early_done = early_reg;
    assign status.gcd_done   = (gy_reg == 64'd0);
    assign status.div_done   = (dcnt_reg == 7'd0);

    always_ff @(posedge clk)
    begin
        unique case (cmd)
            rau_pkg::CMD_LOAD:
            begin
                op_reg <= opcode;
                an_s_reg <= a_num[31]; an_m_reg <= mag32(a_num);
                ad_s_reg <= a_den[31]; ad_m_reg <= mag32(a_den);
                bn_s_reg <= b_num[31]; bn_m_reg <= mag32(b_num);
                bd_s_reg <= b_den[31]; bd_m_reg <= mag32(b_den);
                bad_reg <= (opcode > rau_pkg::OP_RED) || (a_den == 32'd0)
                    || ((opcode != rau_pkg::OP_RED) && (b_den == 32'd0))
                    || ((opcode == rau_pkg::OP_DIV) && (b_num == 32'd0));
            end
            rau_pkg::CMD_MUL1:
            begin
                p1_reg <= {32'd0, ma1} * {32'd0, mb1};
                s1_reg <= ms1;
            end
            rau_pkg::CMD_MUL2:
            begin
                p2_reg <= {32'd0, ma2} * {32'd0, mb2};
                s2_reg <= ms2;
                p3_reg <= {32'd0, ad_m_reg} * {32'd0, bd_m_reg};
                s3_reg <= ad_s_reg ^ bd_s_reg;
            end
            rau_pkg::CMD_FORM:
            begin
                cmp_reg <= 2'd0;
                early_reg <= 1'b0;
                unique case (op_reg) inside
                    rau_pkg::OP_ADD, rau_pkg::OP_SUB:
                    begin
                        nm_reg <= sum_m; dm_reg <= p3_reg;
                        nneg_reg <= sum_s ^ s3_reg;
                    end
                    rau_pkg::OP_MUL:
                    begin
                        nm_reg <= p1_reg; dm_reg <= p2_reg;
                        nneg_reg <= s1_reg ^ s2_reg;
                    end
                    rau_pkg::OP_DIV:
                    begin
                        nm_reg <= p1_reg; dm_reg <= p2_reg;
                        nneg_reg <= s1_reg ^ s2_reg;
                    end
                    rau_pkg::OP_CMP:
                    begin
                        early_reg <= 1'b1;
                        if (sum_m != 64'd0)
                            cmp_reg <= (sum_s ^ s3_reg) ? 2'b11 : 2'b01;
                    end
                    default:
                    begin
                        nm_reg <= {32'd0, an_m_reg}; dm_reg <= {32'd0, ad_m_reg};
                        nneg_reg <= an_s_reg ^ ad_s_reg;
                    end
                endcase
                if (bad_reg)
                    early_reg <= 1'b1;
                else if (op_reg != rau_pkg::OP_CMP && op_reg != rau_pkg::OP_ADD
                         && op_reg != rau_pkg::OP_SUB && op_reg != rau_pkg::OP_MUL
                         && op_reg != rau_pkg::OP_DIV && an_m_reg == 32'd0)
                    early_reg <= 1'b1;
            end
            rau_pkg::CMD_G_INIT:
            begin
                // load the gcd operands and clear the power-of-two count; a zero value settles early
                gx_reg <= nm_reg; gy_reg <= dm_reg; gk_reg <= 7'd0;
                if (nm_reg == 64'd0)
                begin
                    early_reg <= 1'b1; gy_reg <= 64'd0;
                end
            end
            rau_pkg::CMD_G_STEP:
            begin
                if (gk_reg != 7'd127 && !gx_reg[0] && !gy_reg[0])
                begin
                    gx_reg <= gx_reg >> 1; gy_reg <= gy_reg >> 1; gk_reg <= gk_reg + 7'd1;
                end
                else if (!gx_reg[0])
                begin
                    gx_reg <= gx_reg >> 1;
                end
                else
                begin
                    gx_reg <= gx_new; gy_reg <= gy_new;
                end
            end
            rau_pkg::CMD_DIV_INIT:
            begin
                if (!dsel_reg)
                    g_reg <= gx_reg << gk_reg[5:0];
                q_reg <= dsel_reg ? dm_reg : nm_reg;
                r_reg <= 64'd0;
                dcnt_reg <= 7'd64;
            end
            rau_pkg::CMD_DIV_STEP:
            begin
                // count of zero: division finished, hold the quotient
                if (dcnt_reg != 7'd0)
                begin
                    dcnt_reg <= dcnt_reg - 7'd1;
                    if (!r_sub[63] || r_sh[63])
                    begin
                        r_reg <= r_sub; q_reg <= {q_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        r_reg <= r_sh; q_reg <= {q_reg[62:0], 1'b0};
                    end
                end
            end
            rau_pkg::CMD_FINISH:
            begin
                rn_reg <= 32'd0; rd_reg <= 31'd1; rc_reg <= 2'd0; rv_reg <= 1'b1;
                if (bad_reg)
                    rv_reg <= 1'b0;
                else if (op_reg == rau_pkg::OP_CMP)
                    rc_reg <= cmp_reg;
                else if (early_reg)
                    rv_reg <= 1'b1;
                else if (q_reg > HALF - 64'd1
                         || qn_reg > (nneg_reg ? HALF : HALF - 64'd1))
                    rv_reg <= 1'b0;
                else
                begin
                    rn_reg <= nneg_reg ? (32'd0 - qn_reg[31:0]) : qn_reg[31:0];
                    rd_reg <= q_reg[30:0];
                end
            end
            default: ;
        endcase
        if (cmd == rau_pkg::CMD_LOAD)
            dsel_reg <= 1'b0;
        else if (cmd == rau_pkg::CMD_DIV_STEP && dcnt_reg == 7'd1 && !dsel_reg)
        begin
            dsel_reg <= 1'b1;
        end
        if (cmd == rau_pkg::CMD_DIV_STEP && dcnt_reg == 7'd1 && !dsel_reg)
            qn_reg <= (!r_sub[63] || r_sh[63]) ? {q_reg[62:0], 1'b1}
                                              : {q_reg[62:0], 1'b0};
    end

    assign res_num = rn_reg;
    assign res_den = rd_reg;
    assign res_valid = rv_reg;
    assign cmp_sign = rc_reg;
endmodule

/* src/rau_ctrl.sv */
// Controller of the rational arithmetic unit: sequences datapath steps and
// the stream handshake. Depends on rau_pkg and the defines header.
`include "rational_arithmetic_unit_defines.svh"
module rau_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    output logic             idle,
    input  logic             out_ready,
    output logic             out_valid,
    input  rau_pkg::status_t status,
    output rau_pkg::cmd_t    cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_FORM, S_GINIT, S_GSTEP,
        S_DINIT, S_DSTEP, S_FIN, S_OUT
    } state_t;

    state_t state_reg;
    logic   second_reg;
    logic   out_valid_reg;

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  cmd = in_fire ? rau_pkg::CMD_LOAD : rau_pkg::CMD_NONE;
            S_MUL1:  cmd = rau_pkg::CMD_MUL1;
            S_MUL2:  cmd = rau_pkg::CMD_MUL2;
            S_FORM:  cmd = rau_pkg::CMD_FORM;
            S_GINIT: cmd = rau_pkg::CMD_G_INIT;
            S_GSTEP: cmd = rau_pkg::CMD_G_STEP;
            S_DINIT: cmd = rau_pkg::CMD_DIV_INIT;
            S_DSTEP: cmd = rau_pkg::CMD_DIV_STEP;
            S_FIN:   cmd = rau_pkg::CMD_FINISH;
            default: cmd = rau_pkg::CMD_NONE;
        endcase
    end

    assign idle = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            second_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:  if (in_fire) state_reg <= S_MUL1;
                S_MUL1:  state_reg <= S_MUL2;
                S_MUL2:  state_reg <= S_FORM;
                S_FORM:  state_reg <= S_GINIT;
                S_GINIT: state_reg <= status.early_done ? S_FIN : S_GSTEP;
                S_GSTEP:
                begin
                    second_reg <= 1'b0;
                    if (status.early_done)
                        state_reg <= S_FIN;
                    else if (status.gcd_done)
                        state_reg <= S_DINIT;
                end
                S_DINIT: state_reg <= S_DSTEP;
                S_DSTEP:
                    if (status.div_done)
                    begin
                        second_reg <= !second_reg;
                        state_reg <= second_reg ? S_FIN : S_DINIT;
                    end
                S_FIN:
                begin
                    state_reg <= S_OUT;
                    out_valid_reg <= 1'b1;
                end
                S_OUT:   if (!out_valid_reg || out_ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `RAU_ASSERT(a_load_idle, clk, rst_n, (cmd == rau_pkg::CMD_LOAD) |-> !out_valid_reg, "load while holding a result")
    `RAU_ASSERT(a_fin_valid, clk, rst_n, (state_reg == S_FIN) |=> out_valid_reg, "finish did not raise valid")
    `RAU_ASSERT(a_out_state, clk, rst_n, out_valid_reg |-> (state_reg == S_OUT || state_reg == S_IDLE), "valid outside output")
endmodule

/* src/rational_arithmetic_unit.sv */
// Top level of the rational arithmetic unit: controller plus datapath.
// Depends on rau_pkg, rau_ctrl, rau_datapath.
//
//  channel  | dir | tdata (low bit first)               | tuser
//  s_axis   | in  | a_num, a_den, b_num, b_den (128)    | opcode (3)
//  m_axis   | out | res_num, res_den, res_valid (64)    | cmp_sign (2)
//
// One beat at a time: a beat enters only when the unit is idle and no result waits.
// Each beat runs setup (load, first and second multiply, form), then the gcd load and
// binary gcd steps (a shift or a subtract each, plus one to see it end), then two
// restoring divisions (load, 64 steps, done), then finish. Compare and invalid operands
// skip the gcd and divider; a zero product leaves at the first gcd step.
// rst_n clears the controller; a result holds on m_axis_tdata until taken.
module rational_arithmetic_unit #(
    parameter int WORD_BITS = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // a_num, a_den, b_num, b_den
    input  logic [2:0]   s_axis_tuser,  // opcode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,  // res_num, res_den, res_valid
    output logic [1:0]   m_axis_tuser   // cmp_sign
);
    rau_pkg::cmd_t    cmd;
    rau_pkg::status_t status;
    logic             idle;
    logic [31:0]      res_num;
    logic [30:0]      res_den;
    logic             res_valid;

    assign s_axis_tready = idle;

    rau_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_fire(s_axis_tvalid && idle),
        .idle(idle),
        .out_ready(m_axis_tready), .out_valid(m_axis_tvalid),
        .status(status), .cmd(cmd)
    );

    rau_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
        .clk(clk), .cmd(cmd), .opcode(s_axis_tuser),
        .a_num(s_axis_tdata[31:0]), .a_den(s_axis_tdata[63:32]),
        .b_num(s_axis_tdata[95:64]), .b_den(s_axis_tdata[127:96]),
        .status(status),
        .res_num(res_num), .res_den(res_den), .res_valid(res_valid),
        .cmp_sign(m_axis_tuser)
    );

    assign m_axis_tdata = {res_valid, res_den, res_num};
endmodule

/* test/rational_arithmetic_unit_test.sv */
// Testbench for the rational arithmetic unit: directed and random fraction beats,
// each result checked against an in-bench rational predictor.
// Depends on rau_pkg and rational_arithmetic_unit.
`timescale 1ns / 1ps

class fraction_scoreboard;
    logic [63:0] want_data[$];
    logic [1:0]  want_sign[$];
    int errors;
    int checked;

    // binary gcd on magnitudes
    function logic [63:0] gcd_mag(logic [63:0] x, logic [63:0] y);
        int unsigned k;
        logic [63:0] t;
        k = 0;
        while (((x | y) & 64'd1) == 0)
        begin
            x = x >> 1;
            y = y >> 1;
            k++;
        end
        while (x[0] == 1'b0)
            x = x >> 1;
        while (y != 0)
        begin
            while (y[0] == 1'b0)
                y = y >> 1;
            if (x > y)
            begin
                t = x;
                x = y;
                y = t;
            end
            y = y - x;
        end
        return x << k;
    endfunction

    function void note_beat(logic [2:0] op, logic signed [31:0] an,
                            logic signed [31:0] ad, logic signed [31:0] bn,
                            logic signed [31:0] bd);
        // exact signed arithmetic at 66 bits covers every cross-product sum
        logic signed [65:0] num, den, g, n, d;
        logic signed [31:0] rn;
        logic [30:0] rd;
        logic ok;
        logic [1:0] sgn;
        logic [63:0] nm, dm;
        rn = '0;
        rd = 31'd1;
        ok = 1'b0;
        sgn = 2'b00;
        num = '0;
        den = 66'sd1;
        if (op <= rau_pkg::OP_RED && ad != 0 && (op == rau_pkg::OP_RED || bd != 0))
        begin
            ok = 1'b1;
            case (op)
                rau_pkg::OP_ADD:
                begin
                    num = 66'(an) * bd + 66'(ad) * bn;
                    den = 66'(ad) * bd;
                end
                rau_pkg::OP_SUB:
                begin
                    num = 66'(an) * bd - 66'(ad) * bn;
                    den = 66'(ad) * bd;
                end
                rau_pkg::OP_MUL:
                begin
                    num = 66'(an) * bn;
                    den = 66'(ad) * bd;
                end
                rau_pkg::OP_DIV:
                begin
                    num = 66'(an) * bd;
                    den = 66'(ad) * bn;
                    if (bn == 0)
                        ok = 1'b0;
                end
                rau_pkg::OP_CMP:
                begin
                    num = 66'(an) * bd - 66'(bn) * ad;
                    den = 66'(ad) * bd;
                end
                default:
                begin
                    num = 66'(an);
                    den = 66'(ad);
                end
            endcase
            if (ok && op == rau_pkg::OP_CMP)
            begin
                if (num != 0)
                    sgn = ((num < 0) != (den < 0)) ? 2'b11 : 2'b01;
            end
            else if (ok && num != 0)
            begin
                nm = 64'(num < 0 ? -num : num);
                dm = 64'(den < 0 ? -den : den);
                g = 66'(gcd_mag(nm, dm));
                n = 66'(nm) / g;
                d = 66'(dm) / g;
                if ((num < 0) != (den < 0))
                    n = -n;
                if (d > 66'sh7FFFFFFF || n > 66'sh7FFFFFFF || n < -66'sh80000000)
                    ok = 1'b0;
                else
                begin
                    rn = 32'(n);
                    rd = 31'(d);
                end
            end
        end
        want_data.push_back({ok, rd, rn});
        want_sign.push_back(sgn);
    endfunction

    function void check_result(logic [63:0] data, logic [1:0] sgn);
        if (want_data.size() == 0)
        begin
            $display("%t unexpected result data=%h sign=%b", $time, data, sgn);
            errors++;
            return;
        end
        checked++;
        if (data[31:0] !== want_data[0][31:0])
            $display("%t res_num expected %h actual %h", $time, want_data[0][31:0], data[31:0]);
        if (data[62:32] !== want_data[0][62:32])
            $display("%t res_den expected %h actual %h", $time, want_data[0][62:32], data[62:32]);
        if (data[63] !== want_data[0][63])
            $display("%t res_valid expected %b actual %b", $time, want_data[0][63], data[63]);
        if (sgn !== want_sign[0])
            $display("%t cmp_sign expected %b actual %b", $time, want_sign[0], sgn);
        if (data !== want_data[0] || sgn !== want_sign[0])
            errors++;
        void'(want_data.pop_front());
        void'(want_sign.pop_front());
    endfunction
endclass

module rational_arithmetic_unit_test;
    localparam int RANDOM_BEATS = 1250;
    localparam int CYCLE_LIMIT = 2000000;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;   // a_num, a_den, b_num, b_den
    logic [2:0]   s_axis_tuser;   // opcode
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;   // res_num, res_den, res_valid
    logic [1:0]   m_axis_tuser;   // cmp_sign

    fraction_scoreboard board;
    int  cycles;
    int  beats_sent;
    bit  hold_sink;     // long receiver stall request
    bit  stim_done;

    rational_arithmetic_unit uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // Pick a value biased toward edges: zero, -1, extremes, small, or full random.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            3: return 32'hFFFF_FFFF;
            4, 5: return 32'($signed($urandom_range(0, 40)) - 20);
            6: return 32'($urandom_range(0, 65535)) * ($urandom_range(0, 1) ? 32'd1 : -32'd1);
            default: return $urandom;
        endcase
    endfunction

    // One input beat; gap cycles first, then hold until accepted.
    // Valid stays high after acceptance so back-to-back beats need no idle cycle.
    task automatic send_beat(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
                             logic [31:0] bn, logic [31:0] bd, int gap);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {bd, bn, ad, an};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_beat(op, an, ad, bn, bd);
        beats_sent++;
    endtask

    task automatic drain_wait();
        s_axis_tvalid <= 1'b0;
        while (board.want_data.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: random stalls per beat, plus one long hold-off on request.
    initial
    begin
        int wait_n;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_sink)
            begin
                m_axis_tready <= 1'b0;
                repeat (3000) @(posedge clk);
                hold_sink = 0;
            end
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (wait_n > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            board.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    // Cycle limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [2:0] op;
        int burst;
        board = new();
        cycles = 0;
        beats_sent = 0;
        hold_sink = 0;
        stim_done = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = rau_pkg::OP_ADD;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: each opcode, zero denominators, divide by zero, overflow, extremes.
        send_beat(rau_pkg::OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3, 0);
        send_beat(rau_pkg::OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2, 0);
        send_beat(rau_pkg::OP_MUL, -32'd4, 32'd6, 32'd3, -32'd8, 1);
        send_beat(rau_pkg::OP_DIV, 32'd2, 32'd3, 32'd4, 32'd5, 0);
        send_beat(rau_pkg::OP_DIV, 32'd2, 32'd3, 32'd0, 32'd5, 0);
        send_beat(rau_pkg::OP_CMP, 32'd1, 32'd3, 32'd1, 32'd2, 0);
        send_beat(rau_pkg::OP_CMP, 32'd2, 32'd4, 32'd1, 32'd2, 2);
        send_beat(rau_pkg::OP_CMP, -32'd1, -32'd3, 32'd1, 32'd4, 0);
        send_beat(rau_pkg::OP_RED, 32'd12, -32'd18, 32'd0, 32'd0, 0);
        send_beat(rau_pkg::OP_RED, 32'd0, -32'd7, 32'd5, 32'd0, 0);
        send_beat(rau_pkg::OP_ADD, 32'd1, 32'd0, 32'd1, 32'd1, 0);
        send_beat(rau_pkg::OP_ADD, 32'd1, 32'd1, 32'd1, 32'd0, 0);
        send_beat(3'd6, 32'd1, 32'd1, 32'd1, 32'd1, 0);
        send_beat(3'd7, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0);
        send_beat(rau_pkg::OP_RED, 32'h80000000, 32'd1, 32'd0, 32'd1, 0);
        send_beat(rau_pkg::OP_RED, 32'h80000000, 32'hFFFFFFFF, 32'd0, 32'd1, 0);
        send_beat(rau_pkg::OP_RED, 32'h80000000, 32'h80000000, 32'd0, 32'd1, 0);
        send_beat(rau_pkg::OP_MUL, 32'h7FFFFFFF, 32'd1, 32'h7FFFFFFF, 32'd1, 0);
        send_beat(rau_pkg::OP_ADD, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                  32'h7FFFFFFF, 0);
        send_beat(rau_pkg::OP_SUB, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                  32'h80000000, 0);
        send_beat(rau_pkg::OP_DIV, 32'h80000000, 32'd3, 32'h80000000, 32'd3, 0);
        send_beat(rau_pkg::OP_CMP, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                  32'h7FFFFFFF, 0);
        send_beat(rau_pkg::OP_MUL, 32'd0, 32'h80000000, 32'h55555555, 32'hAAAAAAAA, 0);

        // Pause until every result is back.
        drain_wait();
        repeat (10) @(posedge clk);

        // Random part; long receiver hold-off partway through.
        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            if (i == RANDOM_BEATS / 3)
                hold_sink = 1;
            if (i == 2 * RANDOM_BEATS / 3)
                drain_wait();
            op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                              : 3'($urandom_range(0, 5));
            burst = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            send_beat(op, pick_word(), pick_word(), pick_word(), pick_word(), burst);
        end
        stim_done = 1;

        drain_wait();
        repeat (400) @(posedge clk);
        $display("Covered %0d beats: all opcodes, unused codes, zero denominators,",
                 beats_sent);
        $display("divide by zero, overflow and compare signs; %0d results checked.",
                 board.checked);
        if (board.errors == 0 && board.want_data.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
